### src/ivd_pkg.sv
// Shared types, constants and reset-value helpers for the video decoder register block.
// No dependencies.
package ivd_pkg;

   localparam int INDIRECT_DEPTH = 512;
   localparam int DIRECT_DEPTH   = 256;
   localparam int IND_AW         = $clog2(INDIRECT_DEPTH);
   localparam int DIR_AW         = $clog2(DIRECT_DEPTH);

   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_WRITE = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;

   localparam logic [7:0] REG_IND_RD  = 8'h36;
   localparam logic [7:0] REG_IND_WR  = 8'h37;
   localparam logic [7:0] REG_IND_DAT = 8'h38;

   localparam logic [1:0] BYTE_PTR  = 2'd0;
   localparam logic [1:0] BYTE_HIGH = 2'd1;
   localparam logic [1:0] BYTE_LOW  = 2'd2;
   localparam logic [1:0] BYTE_SAT  = 2'd3;

   localparam logic [DIR_AW-1:0] ID0_ADDR = DIR_AW'(32'h00 % DIRECT_DEPTH);
   localparam logic [DIR_AW-1:0] ID1_ADDR = DIR_AW'(32'h01 % DIRECT_DEPTH);
   localparam logic [DIR_AW-1:0] ID2_ADDR = DIR_AW'(32'h02 % DIRECT_DEPTH);
   localparam logic [7:0] ID0_VALUE = 8'hec;
   localparam logic [7:0] ID1_VALUE = 8'h31;
   localparam logic [7:0] ID2_VALUE = 8'h72;

   localparam logic [IND_AW-1:0] FIXED_ADDR  = IND_AW'(32'h0f0 % INDIRECT_DEPTH);
   localparam logic [15:0]       FIXED_VALUE = 16'h0100;
   localparam logic [IND_AW-1:0] STD_A_ADDR  = IND_AW'(32'h020 % INDIRECT_DEPTH);
   localparam logic [IND_AW-1:0] STD_B_ADDR  = IND_AW'(32'h0cb % INDIRECT_DEPTH);
   localparam logic [15:0] STD_A_VALUE0 = 16'h0001;
   localparam logic [15:0] STD_A_VALUE1 = 16'h0000;
   localparam logic [15:0] STD_B_VALUE0 = 16'h0106;
   localparam logic [15:0] STD_B_VALUE1 = 16'h0138;

   typedef struct packed {
      logic clear;
      logic load;
      logic exec;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

   function automatic logic [7:0] dir_reset_value(input logic [DIR_AW-1:0] addr);
      logic [7:0] v;
      v = 8'h00;
      if (addr == ID0_ADDR) v = ID0_VALUE;
      if (addr == ID1_ADDR) v = ID1_VALUE;
      if (addr == ID2_ADDR) v = ID2_VALUE;
      return v;
   endfunction

endpackage

### src/ivd_ctrl.sv
// Controller for the video decoder register block: clearing pass, accept, execute.
// Depends on ivd_pkg.
module ivd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  ivd_pkg::status_type status,
   output ivd_pkg::cmd_type    cmd,
   output logic                busy
);
   import ivd_pkg::*;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EXEC  = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign cmd.clear = (state_ff == ST_CLEAR);
   assign cmd.load  = (state_ff == ST_IDLE) && start;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign busy      = (state_ff != ST_IDLE);

endmodule

### src/ivd_datapath.sv
// Datapath for the video decoder register block: direct register file, indirect store,
// pointer and address registers, result register. Depends on ivd_pkg.
module ivd_datapath (
   input  logic                clock,
   input  logic                reset,
   input  ivd_pkg::cmd_type    cmd,
   output ivd_pkg::status_type status,
   input  logic [1:0]          req_func,
   input  logic                req_start_is_read,
   input  logic [7:0]          req_data_byte,
   input  logic                csr_write_enable,
   input  logic                csr_write_data,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_read_byte,
   output logic                rsp_ack
);
   import ivd_pkg::*;

   logic [7:0]  rf_mem [DIRECT_DEPTH];
   logic [15:0] ind_mem [INDIRECT_DEPTH];

   logic [DIRECT_DEPTH-1:0] valid_ff, valid_in;
   logic [IND_AW-1:0] clr_ff;
   logic [1:0]  func_ff;
   logic        is_read_ff;
   logic [7:0]  data_ff;
   logic [7:0]  rf_q_ff;
   logic [15:0] ind_q_ff;

   logic [7:0]  ptr_ff, ptr_in;
   logic [1:0]  bidx_ff, bidx_in;
   logic [7:0]  held_ff, held_in;
   logic        phase_ff, phase_in;
   logic [IND_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [IND_AW-1:0] wr_addr_ff, wr_addr_in;
   logic [15:0] std_a_ff, std_a_in;
   logic [15:0] std_b_ff, std_b_in;

   logic        strobe_ff;
   logic [7:0]  rb_ff, rb_in;
   logic        ack_ff, ack_in;

   logic        rf_we, ind_we;
   logic [15:0] word;
   logic [15:0] ind_word;
   logic [DIR_AW-1:0] ptr_idx;
   logic        ptr_indirect;

   assign ptr_idx      = ptr_ff[DIR_AW-1:0];
   assign ptr_indirect = (ptr_ff == REG_IND_RD) || (ptr_ff == REG_IND_WR) ||
                         (ptr_ff == REG_IND_DAT);
   assign word         = {held_ff, data_ff};
   assign status.clear_last = (clr_ff == IND_AW'(INDIRECT_DEPTH - 1));

   always_comb begin
      if (rd_addr_ff == STD_A_ADDR)      ind_word = std_a_ff;
      else if (rd_addr_ff == STD_B_ADDR) ind_word = std_b_ff;
      else                               ind_word = ind_q_ff;
   end

   always_comb begin
      ptr_in     = ptr_ff;
      bidx_in    = bidx_ff;
      held_in    = held_ff;
      phase_in   = phase_ff;
      rd_addr_in = rd_addr_ff;
      wr_addr_in = wr_addr_ff;
      std_a_in   = std_a_ff;
      std_b_in   = std_b_ff;
      valid_in   = valid_ff;
      rf_we      = 1'b0;
      ind_we     = 1'b0;
      rb_in      = 8'h00;
      ack_in     = 1'b1;
      if (csr_write_enable) begin
         std_a_in = csr_write_data ? STD_A_VALUE1 : STD_A_VALUE0;
         std_b_in = csr_write_data ? STD_B_VALUE1 : STD_B_VALUE0;
      end
      if (cmd.exec) begin
         case (func_ff)
            FUNC_START: begin
               if (!is_read_ff) bidx_in = BYTE_PTR;
               phase_in = 1'b0;
            end
            FUNC_WRITE: begin
               case (bidx_ff)
                  BYTE_PTR: begin
                     ptr_in = data_ff;
                  end
                  BYTE_HIGH: begin
                     held_in = data_ff;
                     if (!ptr_indirect) begin
                        rf_we             = 1'b1;
                        valid_in[ptr_idx] = 1'b1;
                     end
                  end
                  BYTE_LOW: begin
                     if (ptr_ff == REG_IND_RD) begin
                        rd_addr_in = word[IND_AW-1:0];
                     end else if (ptr_ff == REG_IND_WR) begin
                        wr_addr_in = word[IND_AW-1:0];
                     end else if (ptr_ff == REG_IND_DAT) begin
                        ind_we = 1'b1;
                        if (wr_addr_ff == STD_A_ADDR) std_a_in = word;
                        if (wr_addr_ff == STD_B_ADDR) std_b_in = word;
                     end
                  end
                  default: begin
                  end
               endcase
               if (bidx_ff != BYTE_SAT) bidx_in = 2'(bidx_ff + 2'd1);
            end
            FUNC_READ: begin
               if (ptr_ff == REG_IND_DAT) begin
                  rb_in    = phase_ff ? ind_word[7:0] : ind_word[15:8];
                  phase_in = ~phase_ff;
               end else begin
                  rb_in = valid_ff[ptr_idx] ? rf_q_ff : dir_reset_value(ptr_idx);
               end
            end
            default: begin
               ack_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         valid_ff   <= '0;
         ptr_ff     <= '0;
         bidx_ff    <= BYTE_PTR;
         held_ff    <= '0;
         phase_ff   <= 1'b0;
         rd_addr_ff <= '0;
         wr_addr_ff <= '0;
         std_a_ff   <= STD_A_VALUE0;
         std_b_ff   <= STD_B_VALUE0;
         strobe_ff  <= 1'b0;
      end else begin
         if (cmd.clear) clr_ff <= IND_AW'(clr_ff + 1'b1);
         valid_ff   <= valid_in;
         ptr_ff     <= ptr_in;
         bidx_ff    <= bidx_in;
         held_ff    <= held_in;
         phase_ff   <= phase_in;
         rd_addr_ff <= rd_addr_in;
         wr_addr_ff <= wr_addr_in;
         std_a_ff   <= std_a_in;
         std_b_ff   <= std_b_in;
         strobe_ff  <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_func;
         is_read_ff <= req_start_is_read;
         data_ff    <= req_data_byte;
      end
      if (cmd.exec) begin
         rb_ff  <= rb_in;
         ack_ff <= ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) rf_mem[ptr_idx] <= data_ff;
      if (cmd.load) rf_q_ff <= rf_mem[ptr_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) ind_mem[clr_ff] <= (clr_ff == FIXED_ADDR) ? FIXED_VALUE : 16'h0000;
      else if (ind_we) ind_mem[wr_addr_ff] <= word;
      if (cmd.load) ind_q_ff <= ind_mem[rd_addr_ff];
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_read_byte = rb_ff;
   assign rsp_ack       = ack_ff;

endmodule

### src/i2c_video_decoder_regs.sv
// Top level of the video decoder register block: controller plus datapath.
// Depends on ivd_pkg, ivd_ctrl and ivd_datapath.
//
// One bus event is one request beat: it is taken at a rising edge with start high and
// busy low (req_func, req_start_is_read, req_data_byte). Every event gives one response
// beat: rsp_strobe is high for one cycle with rsp_read_byte and rsp_ack, shown from the
// response registers once the execute cycle ends. The accepting edge also captures the
// register file and indirect store reads (registered memory reads); the execute cycle
// that follows updates state and loads the response register. busy is high for that
// one execute cycle, so no new event is taken until it ends.
// The receiver cannot stall: each response beat is taken at the edge that ends its cycle,
// and the next request may be accepted while a response is shown.
// After reset, a clearing pass loads the indirect store, one word a cycle, through all
// 512 words; busy is high throughout. The csr port (csr_write_enable, csr_write_data)
// selects the video standard, taken at any edge out of reset, even in the clearing pass.
module i2c_video_decoder_regs (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_func,
   input  logic       req_start_is_read,
   input  logic [7:0] req_data_byte,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_ack
);
   import ivd_pkg::*;

   cmd_type    cmd;
   status_type status;

   ivd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   ivd_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_func          (req_func),
      .req_start_is_read (req_start_is_read),
      .req_data_byte     (req_data_byte),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_ack           (rsp_ack)
   );

endmodule
